// File: rtl/isd_pkg.sv
// Shared types and constants of the interrupt source dispatcher.
package isd_pkg;

  localparam int unsigned NumSources = 32;
  localparam int unsigned SrcBits    = 5;
  localparam int unsigned TagBits    = 16;

  typedef enum logic [2:0] {
    REQ_REQUEST  = 3'd0,
    REQ_FREE     = 3'd1,
    REQ_ENABLE   = 3'd2,
    REQ_DISABLE  = 3'd3,
    REQ_DISPATCH = 3'd4,
    REQ_QUERY    = 3'd5
  } req_e;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_OWNER   = 3'd3;
  localparam logic [2:0] ST_DRIVER  = 3'd4;
  localparam logic [2:0] ST_SPUR    = 3'd5;
  localparam logic [2:0] ST_UNREG   = 3'd6;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_DRIVER = 2'd1;
  localparam logic [1:0] KIND_SPUR   = 2'd2;

  localparam logic [2:0] FLG_STD     = 3'd1;
  localparam int unsigned FlgLockBit    = 1;
  localparam int unsigned FlgReplaceBit = 2;

  localparam logic [15:0] DepthMax = 16'hffff;

  // input item
  typedef struct packed {
    logic [31:0]        pending_word;
    logic [TagBits-1:0] owner_tag;
    logic [2:0]         request_flags;
    logic               has_handler;
    logic [5:0]         source;
    logic [2:0]         req_type;
  } item_t;

  // result item
  typedef struct packed {
    logic               last;
    logic [1:0]         handler_kind;
    logic [31:0]        spurious_total;
    logic [31:0]        service_count;
    logic [31:0]        mask_word;
    logic [SrcBits-1:0] served_source;
    logic [2:0]         status;
  } result_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;      // capture input item
    logic exec;      // perform single-result operation
    logic scan;      // service lowest remaining pending bit
  } cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic is_dispatch;
    logic is_valid_type;
    logic pend_any;
  } stat_t;

endpackage

// File: rtl/isd_ctrl.sv
// Controller state machine of the interrupt source dispatcher.
module isd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output isd_pkg::cmd_t cmd_o,
  input  isd_pkg::stat_t stat_i
);
  import isd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free;

  assign out_free    = !ovalid_q || res_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = ovalid_q;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !res_ready_i;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (stat_i.is_dispatch) begin
          state_d = S_SCAN;
        end else if (!stat_i.is_valid_type) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stat_i.pend_any) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          cmd_o.scan = 1'b1;
          ovalid_d   = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.exec, cmd_o.scan}))
    else $error("more than one command");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !res_ready_i |-> !(cmd_o.exec || cmd_o.scan))
    else $error("result overwritten");
endmodule

// File: rtl/isd_dp.sv
// Datapath of the interrupt source dispatcher: tables, counters, result register.
module isd_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  isd_pkg::item_t   item_i,
  input  isd_pkg::cmd_t    cmd_i,
  output isd_pkg::stat_t   stat_o,
  output isd_pkg::result_t res_o
);
  import isd_pkg::*;

  logic [31:0]        mask_q;
  logic [1:0]         kind_q   [NumSources];
  logic [2:0]         flag_q   [NumSources];
  logic [TagBits-1:0] owner_q  [NumSources];
  logic [15:0]        depth_q  [NumSources];
  logic [31:0]        count_q  [NumSources];
  logic [NumSources-1:0] present_q;
  logic [31:0]        spur_q;
  item_t              it_q;
  logic [NumSources-1:0] pend_q;
  result_t            res_q;

  logic [SrcBits-1:0] s;
  logic               in_range;
  logic [SrcBits-1:0] low_idx;
  logic [NumSources-1:0] low_bit;

  assign s        = it_q.source[SrcBits-1:0];
  assign in_range = (it_q.source < 6'(NumSources));

  // lowest pending bit
  assign low_bit = pend_q & (~pend_q + NumSources'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < NumSources; i++) begin
      if (low_bit[i]) low_idx = SrcBits'(i);
    end
  end

  assign stat_o.is_dispatch   = (it_q.req_type == REQ_DISPATCH);
  assign stat_o.is_valid_type = (it_q.req_type <= REQ_QUERY);
  assign stat_o.pend_any      = |pend_q;
  assign res_o                = res_q;

  // item capture and pending word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (cmd_i.load) begin
      pend_q <= (item_i.req_type == REQ_DISPATCH) ? item_i.pending_word : '0;
    end else if (cmd_i.scan) begin
      pend_q <= pend_q & ~low_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
  end

  // table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '1;
      present_q <= '0;
      spur_q    <= '0;
      for (int i = 0; i < NumSources; i++) begin
        kind_q[i]  <= KIND_NONE;
        flag_q[i]  <= '0;
        owner_q[i] <= '0;
        depth_q[i] <= '0;
        count_q[i] <= '0;
      end
    end else if (cmd_i.scan) begin
      if (present_q[low_idx] && kind_q[low_idx] != KIND_NONE) begin
        count_q[low_idx] <= count_q[low_idx] + 32'd1;
        if (kind_q[low_idx] == KIND_SPUR) spur_q <= spur_q + 32'd1;
      end else begin
        mask_q[low_idx] <= 1'b1;
      end
    end else if (cmd_i.exec && in_range) begin
      unique case (it_q.req_type)
        REQ_REQUEST: begin
          logic [2:0] f;
          f = present_q[s] ? flag_q[s] : FLG_STD;
          present_q[s] <= 1'b1;
          if (!f[0] && (f[FlgLockBit] || it_q.request_flags[FlgReplaceBit])) begin
            if (!present_q[s]) begin
              kind_q[s] <= KIND_NONE;
              flag_q[s] <= FLG_STD;
            end
          end else begin
            kind_q[s]  <= it_q.has_handler ? KIND_DRIVER : KIND_NONE;
            flag_q[s]  <= it_q.request_flags;
            owner_q[s] <= it_q.owner_tag;
            if (depth_q[s] == '0) mask_q[s] <= 1'b0;
          end
        end
        REQ_FREE: begin
          present_q[s] <= 1'b1;
          kind_q[s]    <= KIND_SPUR;
          flag_q[s]    <= FLG_STD;
          owner_q[s]   <= '0;
          mask_q[s]    <= 1'b1;
        end
        REQ_ENABLE: begin
          if (depth_q[s] != '0) begin
            depth_q[s] <= depth_q[s] - 16'd1;
            if (depth_q[s] == 16'd1) mask_q[s] <= 1'b0;
          end
        end
        REQ_DISABLE: begin
          if (depth_q[s] == '0) mask_q[s] <= 1'b1;
          if (depth_q[s] != DepthMax) depth_q[s] <= depth_q[s] + 16'd1;
        end
        default: ;
      endcase
    end
  end

  // result formation, reflecting the state after the action
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      res_q.served_source  <= low_idx;
      res_q.last           <= ((pend_q & ~low_bit) == '0);
      res_q.handler_kind   <= kind_q[low_idx];
      if (present_q[low_idx] && kind_q[low_idx] != KIND_NONE) begin
        res_q.status         <= (kind_q[low_idx] == KIND_SPUR) ? ST_SPUR : ST_DRIVER;
        res_q.service_count  <= count_q[low_idx] + 32'd1;
        res_q.spurious_total <= spur_q + ((kind_q[low_idx] == KIND_SPUR) ? 32'd1 : 32'd0);
        res_q.mask_word      <= mask_q;
      end else begin
        res_q.status         <= ST_UNREG;
        res_q.service_count  <= count_q[low_idx];
        res_q.spurious_total <= spur_q;
        res_q.mask_word      <= mask_q | low_bit;
      end
    end else if (cmd_i.exec) begin
      res_q.last           <= 1'b1;
      res_q.served_source  <= s;
      res_q.spurious_total <= spur_q;
      res_q.mask_word      <= mask_q;
      res_q.service_count  <= count_q[s];
      res_q.handler_kind   <= kind_q[s];
      res_q.status         <= ST_OK;
      if (!in_range) begin
        res_q.status        <= ST_UNKNOWN;
        res_q.service_count <= '0;
        res_q.handler_kind  <= KIND_NONE;
      end else begin
        unique case (it_q.req_type)
          REQ_REQUEST: begin
            logic [2:0] f;
            f = present_q[s] ? flag_q[s] : FLG_STD;
            if (!f[0] && (f[FlgLockBit] || it_q.request_flags[FlgReplaceBit])) begin
              res_q.status <= ST_BUSY;
              if (!present_q[s]) res_q.handler_kind <= KIND_NONE;
            end else begin
              res_q.handler_kind <= it_q.has_handler ? KIND_DRIVER : KIND_NONE;
              if (depth_q[s] == '0) res_q.mask_word[s] <= 1'b0;
            end
          end
          REQ_FREE: begin
            if (owner_q[s] != it_q.owner_tag) res_q.status <= ST_OWNER;
            res_q.handler_kind   <= KIND_SPUR;
            res_q.mask_word[s]   <= 1'b1;
          end
          REQ_ENABLE: begin
            if (depth_q[s] == 16'd1) res_q.mask_word[s] <= 1'b0;
          end
          REQ_DISABLE: begin
            if (depth_q[s] == '0) res_q.mask_word[s] <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  a_scan_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> pend_q != '0)
    else $error("scan with no pending bit");
  a_scan_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |=> $countones(pend_q) == $countones($past(pend_q)) - 1)
    else $error("scan did not retire one bit");
  a_spur_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.scan |=> $stable(spur_q))
    else $error("spurious total changed outside dispatch");
endmodule

// File: rtl/interrupt_source_dispatcher_core.sv
// Top level of the interrupt source dispatcher: stream ports, controller and datapath.
// Results are registered after the item is decoded and wait while the output stalls.
// Dispatch: one result per pending bit, one result per cycle while the output is free.
// A new item is taken only in the idle state, once the last one is done; dispatch ends
// with the serial scan of the lowest pending bit and a final empty check.
// Reset: asynchronous, active low; mask all ones, all tables and counters zero.
module interrupt_source_dispatcher_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // {pending_word, owner_tag, request_flags, has_handler, source, req_type} from bit 60 down to bit 0
  input  logic [63:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, served_source, mask_word, service_count, spurious_total, handler_kind;
  // lowest bit up, zero padded
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import isd_pkg::*;

  item_t   item;
  result_t res;
  cmd_t    cmd;
  stat_t   stat;

  assign item = item_t'(s_axis_tdata[60:0]);

  isd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  isd_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item),
    .cmd_i (cmd),
    .stat_o(stat),
    .res_o (res)
  );

  assign m_axis_tdata = {6'd0, res.handler_kind, res.spurious_total, res.service_count,
                         res.mask_word, res.served_source, res.status};
  assign m_axis_tlast = res.last;
endmodule

// File: bench/tb_interrupt_source_dispatcher_core.sv
// Self-checking testbench for the interrupt source dispatcher core.
module tb_interrupt_source_dispatcher_core;
  import isd_pkg::*;

  localparam logic [2:0] REQ_RSVD_LO = 3'd6;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;
  localparam logic [2:0] FLG_LOCKED  = 3'd2;
  localparam logic [2:0] FLG_REPLACE = 3'd4;
  localparam int unsigned MaxShown   = 10;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;

  interrupt_source_dispatcher_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the datapath tables
  logic [31:0]        shadow_mask;
  logic [1:0]         shadow_kind  [NumSources];
  logic [2:0]         shadow_flags [NumSources];
  logic [TagBits-1:0] shadow_owner [NumSources];
  logic [15:0]        shadow_depth [NumSources];
  logic [31:0]        shadow_count [NumSources];
  logic               shadow_known [NumSources];
  logic [31:0]        shadow_spur;

  result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  function automatic void shadow_reset();
    shadow_mask = '1;
    shadow_spur = '0;
    for (int i = 0; i < NumSources; i++) begin
      shadow_kind[i]  = KIND_NONE;
      shadow_flags[i] = '0;
      shadow_owner[i] = '0;
      shadow_depth[i] = '0;
      shadow_count[i] = '0;
      shadow_known[i] = 1'b0;
    end
  endfunction

  function automatic void push_result(logic [2:0] st, logic [4:0] src, logic [31:0] cnt,
                                      logic [1:0] kind, logic lst);
    result_t r;
    r.status         = st;
    r.served_source  = src;
    r.mask_word      = shadow_mask;
    r.service_count  = cnt;
    r.spurious_total = shadow_spur;
    r.handler_kind   = kind;
    r.last           = lst;
    pending_results.push_back(r);
  endfunction

  // Work out the results one accepted item causes and update the shadow tables
  function automatic void predict_item(item_t it);
    logic [4:0]  s;
    logic [31:0] bitm;
    logic [2:0]  st;
    int          top;
    s    = it.source[4:0];
    bitm = 32'd1 << s;
    st   = ST_OK;
    if (it.req_type == REQ_DISPATCH) begin
      top = -1;
      for (int i = 0; i < NumSources; i++) if (it.pending_word[i]) top = i;
      for (int i = 0; i < NumSources; i++) begin
        if (it.pending_word[i]) begin
          if (shadow_known[i] && shadow_kind[i] != KIND_NONE) begin
            shadow_count[i]++;
            if (shadow_kind[i] == KIND_SPUR) begin
              shadow_spur++;
              st = ST_SPUR;
            end else begin
              st = ST_DRIVER;
            end
          end else begin
            shadow_mask[i] = 1'b1;
            st = ST_UNREG;
          end
          push_result(st, 5'(i), shadow_count[i], shadow_kind[i], i == top);
        end
      end
      return;
    end
    if (it.req_type == REQ_RSVD_LO || it.req_type == REQ_RSVD_HI) return;
    if (it.source >= NumSources) begin
      push_result(ST_UNKNOWN, s, '0, KIND_NONE, 1'b1);
      return;
    end
    case (it.req_type)
      REQ_REQUEST: begin
        if (!shadow_known[s]) begin
          shadow_known[s] = 1'b1;
          shadow_kind[s]  = KIND_NONE;
          shadow_flags[s] = FLG_STD;
        end
        if ((shadow_flags[s] & FLG_STD) == '0 &&
            ((shadow_flags[s] & FLG_LOCKED) != '0 || (it.request_flags & FLG_REPLACE) != '0)) begin
          st = ST_BUSY;
        end else begin
          shadow_kind[s]  = it.has_handler ? KIND_DRIVER : KIND_NONE;
          shadow_flags[s] = it.request_flags;
          shadow_owner[s] = it.owner_tag;
          if (shadow_depth[s] == '0) shadow_mask &= ~bitm;
        end
      end
      REQ_FREE: begin
        if (shadow_owner[s] != it.owner_tag) st = ST_OWNER;
        shadow_known[s] = 1'b1;
        shadow_kind[s]  = KIND_SPUR;
        shadow_flags[s] = FLG_STD;
        shadow_owner[s] = '0;
        shadow_mask    |= bitm;
      end
      REQ_ENABLE: begin
        if (shadow_depth[s] != '0) begin
          shadow_depth[s]--;
          if (shadow_depth[s] == '0) shadow_mask &= ~bitm;
        end
      end
      REQ_DISABLE: begin
        if (shadow_depth[s] == '0) shadow_mask |= bitm;
        if (shadow_depth[s] != DepthMax) shadow_depth[s]++;
      end
      default: ;
    endcase
    push_result(st, s, shadow_count[s], shadow_kind[s], 1'b1);
  endfunction

  function automatic item_t make_item(logic [2:0] t, logic [5:0] src, logic hh,
                                      logic [2:0] fl, logic [15:0] tag, logic [31:0] pend);
    item_t it;
    it.req_type      = req_e'(t);
    it.source        = src;
    it.has_handler   = hh;
    it.request_flags = fl;
    it.owner_tag     = tag;
    it.pending_word  = pend;
    return it;
  endfunction

  // Send one item; called at a falling edge, returns at a falling edge
  task automatic send_item(item_t it);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 64'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(it);
    @(negedge clk_i);
  endtask

  // Receiver stall pattern: the mode is redrawn at random among four modes
  int unsigned rx_cycle = 0;
  int unsigned rx_mode  = 0;
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
      2:       m_axis_tready <= (rx_cycle % 4 != 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got      = result_t'({m_axis_tlast, m_axis_tdata[105:0]});
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.served_source !== want.served_source ||
            got.mask_word !== want.mask_word || got.service_count !== want.service_count ||
            got.spurious_total !== want.spurious_total ||
            got.handler_kind !== want.handler_kind || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  // Unknown sources, reserved kinds, edge cases of request, free, enable, disable and dispatch
  task automatic test_directed();
    for (int t = 0; t <= 5; t++)
      if (t != REQ_DISPATCH) send_item(make_item(3'(t), 6'd63, 1'b1, 3'd7, 16'hffff, '1));
    send_item(make_item(REQ_QUERY, 6'd32, 1'b0, 3'd0, 16'h0, '0));
    send_item(make_item(REQ_RSVD_LO, 6'd0, 1'b0, 3'd0, 16'h0, '0));
    send_item(make_item(REQ_RSVD_HI, 6'd1, 1'b1, 3'd7, 16'hffff, '1));
    send_item(make_item(REQ_FREE, 6'd7, 1'b0, 3'd0, 16'h1234, '0));
    send_item(make_item(REQ_ENABLE, 6'd3, 1'b0, 3'd0, 16'h0, '0));
    send_item(make_item(REQ_REQUEST, 6'd0, 1'b1, FLG_STD, 16'hffff, '0));
    send_item(make_item(REQ_REQUEST, 6'd1, 1'b0, FLG_STD, 16'h0001, '0));
    send_item(make_item(REQ_REQUEST, 6'd2, 1'b1, FLG_LOCKED, 16'h00aa, '0));
    send_item(make_item(REQ_REQUEST, 6'd2, 1'b1, FLG_STD, 16'h00bb, '0));
    send_item(make_item(REQ_REQUEST, 6'd31, 1'b1, 3'd0, 16'h5555, '0));
    send_item(make_item(REQ_REQUEST, 6'd31, 1'b1, FLG_REPLACE, 16'h5555, '0));
    send_item(make_item(REQ_FREE, 6'd0, 1'b0, 3'd0, 16'h0000, '0));
    send_item(make_item(REQ_DISABLE, 6'd1, 1'b0, 3'd0, 16'h0, '0));
    send_item(make_item(REQ_DISPATCH, 6'd0, 1'b0, 3'd0, 16'h0, '0));
    send_item(make_item(REQ_DISPATCH, 6'd0, 1'b0, 3'd0, 16'h0, 32'hffff_ffff));
    send_item(make_item(REQ_DISPATCH, 6'd0, 1'b0, 3'd0, 16'h0, 32'h8000_0001));
    send_item(make_item(REQ_ENABLE, 6'd1, 1'b0, 3'd0, 16'h0, '0));
    send_item(make_item(REQ_QUERY, 6'd0, 1'b0, 3'd0, 16'h0, '0));
  endtask

  // Nested disables, then more enables than disables, so that enables also arrive at depth zero
  task automatic test_nested_disable();
    gaps_on = 1'b0;
    for (int i = 0; i < 6; i++)
      send_item(make_item(REQ_DISABLE, 6'd5, 1'b0, 3'd0, 16'h0, '0));
    for (int i = 0; i < 8; i++)
      send_item(make_item(REQ_ENABLE, 6'd5, 1'b0, 3'd0, 16'h0, '0));
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed traffic on a few sources, with some raw noise
  task automatic test_random();
    item_t it;
    for (int n = 0; n < 80; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        it = make_item(3'($urandom_range(0, 5)), 6'($urandom_range(0, 7)),
                       1'($urandom), 3'($urandom), 16'($urandom_range(0, 3)),
                       32'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) it.pending_word = $urandom;
      end else begin
        it = make_item(3'($urandom), 6'($urandom), 1'($urandom), 3'($urandom),
                       16'($urandom), $urandom);
      end
      send_item(it);
    end
  endtask

  initial begin
    shadow_reset();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_nested_disable();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[interrupt_source_dispatcher_core] OK");
    end else begin
      $display("[interrupt_source_dispatcher_core] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30000000;
    $display("[interrupt_source_dispatcher_core] ERROR");
    $finish;
  end

endmodule
